// File: rtl/modal_assurance_criterion_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the modal assurance criterion block
// Clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef MODAL_ASSURANCE_CRITERION_TOP_ASSERT_SVH
`define MODAL_ASSURANCE_CRITERION_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define MAC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define MAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mac_pkg.sv
// ----------------------------------------------------------------------------
// mac_pkg
// Widths, sequencer states and the multiplier request of the modal
// assurance criterion block.
// ----------------------------------------------------------------------------
package mac_pkg;

  localparam int SAMPLE_WIDTH     = 16;
  localparam int ACC_WIDTH        = 48;
  localparam int RESULT_FRAC_BITS = 16;

  localparam int HALF_WIDTH = (ACC_WIDTH + 1) / 2;
  localparam int MUL_WIDTH  = (SAMPLE_WIDTH > HALF_WIDTH) ? SAMPLE_WIDTH : HALF_WIDTH;
  localparam int PROD_WIDTH = 2 * MUL_WIDTH;
  localparam int WACC_WIDTH = 2 * ACC_WIDTH;
  localparam int REM_WIDTH  = WACC_WIDTH + 1;
  localparam int CSUM_WIDTH =
    ((ACC_WIDTH > PROD_WIDTH + 1) ? ACC_WIDTH : PROD_WIDTH + 1) + 1;
  localparam int NSUM_WIDTH = ((ACC_WIDTH > PROD_WIDTH) ? ACC_WIDTH : PROD_WIDTH) + 1;
  localparam int Q_WIDTH       = RESULT_FRAC_BITS + 1;
  localparam int BIT_CNT_WIDTH = $clog2(RESULT_FRAC_BITS);

  localparam logic [2:0] ELEM_LAST_STEP = 3'd3;
  localparam logic [2:0] WMUL_LAST_STEP = 3'd4;

  localparam logic [Q_WIDTH-1:0] MAC_ONE = {1'b1, {RESULT_FRAC_BITS{1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_ELEM,
    S_CHECK,
    S_WMUL,
    S_CMP,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic                 en;
    logic [MUL_WIDTH-1:0] op_a;
    logic [MUL_WIDTH-1:0] op_b;
  } mul_req_t;

endpackage

// File: rtl/modal_assurance_criterion_top.sv
// ----------------------------------------------------------------------------
// modal_assurance_criterion_top
// Accumulates cross and self products of two mode shapes on one shared
// multiplier and returns (a.b)^2 / ((a.a)(b.b)) as an unsigned Q1.16 value.
//
//   channel | signals                        | transfer
//   --------+--------------------------------+-------------------------------
//   in      | in_valid in_ready a_elem       | one element pair per request
//           | b_elem last                    |
//   out     | out_valid out_ready mac_value  | one result per request with
//           | degenerate                     | last set
//
// An element pair is accepted, then takes four multiplier steps. A pair with
// last set then goes through a check, the two wide products, a compare, one
// restoring division step per fraction bit and the output state; a zero norm
// goes from the check straight to output, and a ratio of one or more skips the division.
// Reset clears the three sums and the sequencer.
// A result waits in the output register while the next pair is taken; a
// further finished result holds in the output state until it is free.
// ----------------------------------------------------------------------------
`include "modal_assurance_criterion_top_assert.svh"

module modal_assurance_criterion_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [15:0]                   a_elem,
  input  logic signed [15:0]                   b_elem,
  input  logic                                 last,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [mac_pkg::Q_WIDTH-1:0]          mac_value,
  output logic                                 degenerate
);
  import mac_pkg::*;

  localparam logic [CSUM_WIDTH-1:0] CROSS_MAX_W =
    {{(CSUM_WIDTH-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
  localparam logic [CSUM_WIDTH-1:0] CROSS_MIN_W =
    {{(CSUM_WIDTH-ACC_WIDTH+1){1'b1}}, {(ACC_WIDTH-1){1'b0}}};
  localparam logic [NSUM_WIDTH-1:0] NORM_MAX_W =
    {{(NSUM_WIDTH-ACC_WIDTH){1'b0}}, {ACC_WIDTH{1'b1}}};

  state_t state, state_next;
  logic [2:0]                  step;
  logic                        phase;
  logic [BIT_CNT_WIDTH-1:0]    bit_cnt;
  logic [SAMPLE_WIDTH-1:0]     a_mag, b_mag;
  logic                        cross_neg;
  logic                        last_q;
  logic [ACC_WIDTH-1:0]        cross_sum, first_norm_sum, second_norm_sum;
  logic [WACC_WIDTH-1:0]       wacc;
  logic [REM_WIDTH-1:0]        rem;
  logic [Q_WIDTH-1:0]          q;
  logic                        degen_q;

  mul_req_t                    mul_req;
  logic [PROD_WIDTH-1:0]       prod;

  logic [SAMPLE_WIDTH-1:0]     a_s, b_s, a_abs, b_abs;
  logic signed [CSUM_WIDTH-1:0] c_ext, p_cross, cross_add;
  logic [ACC_WIDTH-1:0]        cross_sat;
  logic [ACC_WIDTH-1:0]        n_sel, norm_sat;
  logic [NSUM_WIDTH-1:0]       norm_add;
  logic [ACC_WIDTH-1:0]        cmag, wx, wy;
  logic [MUL_WIDTH-1:0]        wx0, wx1, wy0, wy1;
  logic [1:0]                  prev_k;
  logic [WACC_WIDTH-1:0]       pp, wacc_sum;
  logic [REM_WIDTH-1:0]        den_ext, r2;
  logic                        cmp_ge, div_ge, norm_zero, out_load;

  mac_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  always_comb begin
    a_s   = a_elem[SAMPLE_WIDTH-1:0];
    b_s   = b_elem[SAMPLE_WIDTH-1:0];
    a_abs = (a_s ^ {SAMPLE_WIDTH{a_s[SAMPLE_WIDTH-1]}}) + SAMPLE_WIDTH'(a_s[SAMPLE_WIDTH-1]);
    b_abs = (b_s ^ {SAMPLE_WIDTH{b_s[SAMPLE_WIDTH-1]}}) + SAMPLE_WIDTH'(b_s[SAMPLE_WIDTH-1]);

    c_ext   = $signed({{(CSUM_WIDTH-ACC_WIDTH){cross_sum[ACC_WIDTH-1]}}, cross_sum});
    p_cross = $signed({{(CSUM_WIDTH-PROD_WIDTH){1'b0}}, prod});
    cross_add = cross_neg ? (c_ext - p_cross) : (c_ext + p_cross);
    if (cross_add > $signed(CROSS_MAX_W)) begin
      cross_sat = CROSS_MAX_W[ACC_WIDTH-1:0];
    end else if (cross_add < $signed(CROSS_MIN_W)) begin
      cross_sat = CROSS_MIN_W[ACC_WIDTH-1:0];
    end else begin
      cross_sat = cross_add[ACC_WIDTH-1:0];
    end

    n_sel    = (step == 3'd2) ? first_norm_sum : second_norm_sum;
    norm_add = {{(NSUM_WIDTH-ACC_WIDTH){1'b0}}, n_sel}
             + {{(NSUM_WIDTH-PROD_WIDTH){1'b0}}, prod};
    norm_sat = (norm_add > NORM_MAX_W) ? NORM_MAX_W[ACC_WIDTH-1:0]
                                       : norm_add[ACC_WIDTH-1:0];

    cmag = cross_sum[ACC_WIDTH-1] ? (~cross_sum + ACC_WIDTH'(1)) : cross_sum;
    wx   = phase ? first_norm_sum : cmag;
    wy   = phase ? second_norm_sum : cmag;
    wx0  = MUL_WIDTH'(wx[HALF_WIDTH-1:0]);
    wx1  = MUL_WIDTH'(wx[ACC_WIDTH-1:HALF_WIDTH]);
    wy0  = MUL_WIDTH'(wy[HALF_WIDTH-1:0]);
    wy1  = MUL_WIDTH'(wy[ACC_WIDTH-1:HALF_WIDTH]);

    prev_k = step[1:0] - 2'd1;
    case (prev_k)
      2'd0:    pp = WACC_WIDTH'(prod);
      2'd1:    pp = WACC_WIDTH'(prod) << HALF_WIDTH;
      2'd2:    pp = WACC_WIDTH'(prod) << HALF_WIDTH;
      default: pp = WACC_WIDTH'(prod) << (2 * HALF_WIDTH);
    endcase
    wacc_sum = wacc + pp;

    den_ext   = {1'b0, wacc};
    r2        = {rem[REM_WIDTH-2:0], 1'b0};
    cmp_ge    = rem >= den_ext;
    div_ge    = r2 >= den_ext;
    norm_zero = (first_norm_sum == '0) || (second_norm_sum == '0);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_ELEM;
      S_ELEM:  if (step == ELEM_LAST_STEP) state_next = last_q ? S_CHECK : S_IDLE;
      S_CHECK: state_next = norm_zero ? S_OUT : S_WMUL;
      S_WMUL:  if (step == WMUL_LAST_STEP && phase) state_next = S_CMP;
      S_CMP:   state_next = cmp_ge ? S_OUT : S_DIV;
      S_DIV:   if (bit_cnt == BIT_CNT_WIDTH'(RESULT_FRAC_BITS - 1)) state_next = S_OUT;
      S_OUT:   if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    out_load     = 1'b0;
    mul_req.en   = 1'b0;
    mul_req.op_a = MUL_WIDTH'(a_mag);
    mul_req.op_b = MUL_WIDTH'(b_mag);
    unique case (state)
      S_IDLE: in_ready = 1'b1;
      S_ELEM: begin
        mul_req.en = 1'b1;
        case (step)
          3'd0: begin
            mul_req.op_a = MUL_WIDTH'(a_mag);
            mul_req.op_b = MUL_WIDTH'(b_mag);
          end
          3'd1: begin
            mul_req.op_a = MUL_WIDTH'(a_mag);
            mul_req.op_b = MUL_WIDTH'(a_mag);
          end
          default: begin
            mul_req.op_a = MUL_WIDTH'(b_mag);
            mul_req.op_b = MUL_WIDTH'(b_mag);
          end
        endcase
      end
      S_WMUL: begin
        mul_req.en   = 1'b1;
        mul_req.op_a = step[1] ? wx1 : wx0;
        mul_req.op_b = step[0] ? wy1 : wy0;
      end
      S_OUT: out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      step            <= '0;
      phase           <= 1'b0;
      bit_cnt         <= '0;
      cross_sum       <= '0;
      first_norm_sum  <= '0;
      second_norm_sum <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            a_mag     <= a_abs;
            b_mag     <= b_abs;
            cross_neg <= a_s[SAMPLE_WIDTH-1] ^ b_s[SAMPLE_WIDTH-1];
            last_q    <= last;
            step      <= '0;
          end
        end
        S_ELEM: begin
          step <= step + 3'd1;
          case (step)
            3'd1:    cross_sum       <= cross_sat;
            3'd2:    first_norm_sum  <= norm_sat;
            3'd3:    second_norm_sum <= norm_sat;
            default: ;
          endcase
        end
        S_CHECK: begin
          step    <= '0;
          phase   <= 1'b0;
          wacc    <= '0;
          q       <= '0;
          degen_q <= norm_zero;
        end
        S_WMUL: begin
          if (step == WMUL_LAST_STEP) begin
            step <= '0;
            if (!phase) begin
              rem   <= REM_WIDTH'(wacc_sum);
              wacc  <= '0;
              phase <= 1'b1;
            end else begin
              wacc <= wacc_sum;
            end
          end else begin
            step <= step + 3'd1;
            if (step != 3'd0) begin
              wacc <= wacc_sum;
            end
          end
        end
        S_CMP: begin
          bit_cnt <= '0;
          q       <= cmp_ge ? MAC_ONE : '0;
        end
        S_DIV: begin
          rem     <= div_ge ? (r2 - den_ext) : r2;
          q       <= {q[Q_WIDTH-2:0], div_ge};
          bit_cnt <= bit_cnt + BIT_CNT_WIDTH'(1);
        end
        S_OUT: begin
          if (out_load) begin
            mac_value       <= q;
            degenerate      <= degen_q;
            cross_sum       <= '0;
            first_norm_sum  <= '0;
            second_norm_sum <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  `MAC_ASSERT_IMP(a_degen_zero, out_valid && degenerate, mac_value == '0, "degenerate result not zero")
  `MAC_ASSERT_IMP(a_mac_range, out_valid, mac_value <= MAC_ONE, "result above one")
  `MAC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready while busy")
  `MAC_ASSERT_IMP(a_div_rem_bound, state == S_DIV, rem < den_ext, "remainder not below divisor")

endmodule

// File: rtl/mac_mul.sv
// ----------------------------------------------------------------------------
// mac_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module mac_mul (
  input  logic                              clk,
  input  mac_pkg::mul_req_t                 req,
  output logic [mac_pkg::PROD_WIDTH-1:0]    prod
);
  import mac_pkg::*;

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= PROD_WIDTH'(req.op_a) * PROD_WIDTH'(req.op_b);
    end
  end

endmodule

// File: tb/mac_result_checker.sv
// ----------------------------------------------------------------------------
// mac_result_checker
// Watches both channels of the modal assurance criterion block. It keeps its
// own cross and self sums for every accepted request, forms the expected
// correlation when a request carries last, and compares each accepted result
// with the oldest expected one.
// ----------------------------------------------------------------------------
module mac_result_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic signed [15:0]           a_elem,
  input  logic signed [15:0]           b_elem,
  input  logic                         last,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [mac_pkg::Q_WIDTH-1:0]  mac_value,
  input  logic                         degenerate,
  output int                           fail_count,
  output int                           pending
);
  import mac_pkg::*;

  localparam int SUM_WIDTH   = ACC_WIDTH + 2 * SAMPLE_WIDTH + 1;
  localparam int RATIO_WIDTH = 2 * ACC_WIDTH + RESULT_FRAC_BITS;

  typedef struct packed {
    logic [Q_WIDTH-1:0] mac;
    logic               degen;
  } mac_result_t;

  logic signed [ACC_WIDTH-1:0] cross_acc;
  logic [ACC_WIDTH-1:0]        first_norm;
  logic [ACC_WIDTH-1:0]        second_norm;
  mac_result_t                 expected_macs[$];
  mac_result_t                 want;

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic predict_pair(input logic [15:0] a_raw, input logic [15:0] b_raw,
                              input logic lst);
    logic signed [SAMPLE_WIDTH-1:0]   a;
    logic signed [SAMPLE_WIDTH-1:0]   b;
    logic signed [2*SAMPLE_WIDTH-1:0] sq_a;
    logic signed [2*SAMPLE_WIDTH-1:0] sq_b;
    logic signed [SUM_WIDTH-1:0]      cross_next;
    logic signed [SUM_WIDTH-1:0]      cross_hi;
    logic signed [SUM_WIDTH-1:0]      cross_lo;
    logic [SUM_WIDTH-1:0]             first_next;
    logic [SUM_WIDTH-1:0]             second_next;
    logic [SUM_WIDTH-1:0]             norm_hi;
    logic [ACC_WIDTH-1:0]             cross_mag;
    logic [RATIO_WIDTH-1:0]           num;
    logic [RATIO_WIDTH-1:0]           den;
    mac_result_t                      res;
    a = a_raw[SAMPLE_WIDTH-1:0];
    b = b_raw[SAMPLE_WIDTH-1:0];
    cross_hi = '0;
    cross_hi[ACC_WIDTH-2:0] = '1;
    cross_lo = -cross_hi - 1;
    norm_hi = '0;
    norm_hi[ACC_WIDTH-1:0] = '1;

    sq_a = a * a;
    sq_b = b * b;
    cross_next  = cross_acc + a * b;
    first_next  = first_norm + $unsigned(sq_a);
    second_next = second_norm + $unsigned(sq_b);

    // saturate all three sums
    if (cross_next > cross_hi)
      cross_acc = cross_hi[ACC_WIDTH-1:0];
    else if (cross_next < cross_lo)
      cross_acc = cross_lo[ACC_WIDTH-1:0];
    else
      cross_acc = cross_next[ACC_WIDTH-1:0];
    first_norm  = (first_next > norm_hi) ? norm_hi[ACC_WIDTH-1:0] : first_next[ACC_WIDTH-1:0];
    second_norm = (second_next > norm_hi) ? norm_hi[ACC_WIDTH-1:0] :
                                            second_next[ACC_WIDTH-1:0];

    if (lst) begin
      res.degen = (first_norm == '0) || (second_norm == '0);
      res.mac   = '0;
      if (!res.degen) begin
        cross_mag = cross_acc[ACC_WIDTH-1] ? -cross_acc : cross_acc;
        num = cross_mag * cross_mag;
        den = first_norm * second_norm;
        if (num >= den)
          res.mac = MAC_ONE;
        else
          res.mac = Q_WIDTH'((num << RESULT_FRAC_BITS) / den);
      end
      expected_macs = {expected_macs, res};
      cross_acc   = '0;
      first_norm  = '0;
      second_norm = '0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cross_acc   = '0;
      first_norm  = '0;
      second_norm = '0;
      expected_macs.delete();
      pending = 0;
    end else begin
      if (in_valid && in_ready)
        predict_pair(a_elem, b_elem, last);
      if (out_valid && out_ready) begin
        if (expected_macs.size() == 0) begin
          report_mismatch("result with no request pending");
        end else begin
          want = expected_macs.pop_front();
          if (mac_value !== want.mac)
            report_mismatch($sformatf("mac_value %0d, expected %0d", mac_value, want.mac));
          if (degenerate !== want.degen)
            report_mismatch($sformatf("degenerate %0b, expected %0b", degenerate,
                                      want.degen));
        end
      end
      pending = expected_macs.size();
    end
  end

endmodule

// File: tb/modal_assurance_criterion_top_tb.sv
// ----------------------------------------------------------------------------
// modal_assurance_criterion_top_tb
// Streams element pairs of mode-shape vectors into the block: corner vectors
// first, then a long output hold-off, then random vectors under several idle
// and stall mixes. The checker predicts every correlation; this module gives
// the verdict.
// ----------------------------------------------------------------------------
module modal_assurance_criterion_top_tb;
  import mac_pkg::*;

  localparam int CYCLE_LIMIT  = 200_000;
  localparam int PHASE_PAIRS  = 85;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 60;

  localparam logic signed [15:0] ELEM_MAX = 16'sh7fff;
  localparam logic signed [15:0] ELEM_MIN = 16'sh8000;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic signed [15:0]  a_elem;
  logic signed [15:0]  b_elem;
  logic                last;
  logic                out_valid;
  logic                out_ready;
  logic [Q_WIDTH-1:0]  mac_value;
  logic                degenerate;

  int fail_count;
  int pending;
  int send_idle_pct;
  int stall_pct;
  bit hold_req;
  int pairs_sent;
  int cycle_count;

  modal_assurance_criterion_top DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .a_elem     (a_elem),
    .b_elem     (b_elem),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .mac_value  (mac_value),
    .degenerate (degenerate)
  );

  mac_result_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .a_elem     (a_elem),
    .b_elem     (b_elem),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .mac_value  (mac_value),
    .degenerate (degenerate),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : receiver
    int hold_left;
    bit hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_used) begin
        hold_left = HOLD_CYCLES;
        hold_used = 1'b1;
      end
      if (!hold_req)
        hold_used = 1'b0;
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** modal_assurance_criterion_top: FAILED **");
    $finish;
  end

  task automatic send_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                           input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    a_elem   <= a;
    b_elem   <= b;
    last     <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pairs_sent++;
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] corner_sample();
    case ($urandom_range(4))
      0:       return ELEM_MIN;
      1:       return ELEM_MAX;
      2:       return -16'sd1;
      3:       return 16'sd1;
      default: return 16'sd0;
    endcase
  endfunction

  task automatic send_random_vector(input int max_len);
    int                 len;
    int                 style;
    int                 shift;
    bit                 flip;
    bit                 zero_a;
    logic signed [15:0] a;
    logic signed [15:0] b;
    len    = ($urandom_range(7) == 0) ? $urandom_range(max_len, 1) : $urandom_range(4, 1);
    style  = $urandom_range(4);
    shift  = $urandom_range(3);
    flip   = 1'($urandom_range(1));
    zero_a = 1'($urandom_range(1));
    for (int i = 0; i < len; i++) begin
      a = 16'($urandom);
      b = 16'($urandom);
      case (style)
        1: begin
          // near-parallel vectors land close to one
          b = a >>> shift;
          if (flip)
            b = -b;
          if ($urandom_range(3) == 0)
            b[0] = ~b[0];
        end
        2: begin
          a = corner_sample();
          b = corner_sample();
        end
        3: begin
          if (zero_a)
            a = '0;
          else
            b = '0;
        end
        4: begin
          a = 16'($urandom_range(8));
          a = a - 16'sd4;
          b = 16'($urandom_range(8));
          b = b - 16'sd4;
        end
        default: ;
      endcase
      send_pair(a, b, i == len - 1);
    end
  endtask

  initial begin : stimulus
    int phase_start;
    rst           = 1'b1;
    in_valid      = 1'b0;
    a_elem        = '0;
    b_elem        = '0;
    last          = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    pairs_sent    = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // parallel and antiparallel vectors give exactly one
    send_pair(ELEM_MAX, ELEM_MAX, 1'b1);
    send_pair(ELEM_MIN, ELEM_MIN, 1'b1);
    send_pair(ELEM_MIN, ELEM_MAX, 1'b1);
    send_pair(16'sd100, -16'sd200, 1'b0);
    send_pair(16'sd50, -16'sd100, 1'b1);
    // zero norms
    send_pair(16'sd0, 16'sd5, 1'b1);
    send_pair(-16'sd5, 16'sd0, 1'b1);
    send_pair(16'sd0, 16'sd0, 1'b0);
    send_pair(16'sd0, 16'sd0, 1'b1);
    // orthogonal vectors
    send_pair(16'sd1, 16'sd0, 1'b0);
    send_pair(16'sd0, 16'sd1, 1'b1);
    send_pair(16'sd1, 16'sd1, 1'b0);
    send_pair(16'sd1, -16'sd1, 1'b1);
    // truncated fractions
    send_pair(ELEM_MAX, ELEM_MIN, 1'b0);
    send_pair(-16'sd1, 16'sd1, 1'b0);
    send_pair(16'sd12345, -16'sd23456, 1'b1);
    send_pair(-16'sd1, -16'sd1, 1'b1);
    send_pair(16'sd3, 16'sd1, 1'b0);
    send_pair(16'sd1, 16'sd3, 1'b1);
    send_pair(ELEM_MAX, 16'sd1, 1'b0);
    send_pair(16'sd1, ELEM_MAX, 1'b1);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);

    // hold the output while requests keep coming
    hold_req <= 1'b1;
    for (int v = 0; v < 12; v++)
      send_random_vector(3);
    hold_req <= 1'b0;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          stall_pct    <= 0;
        end
        1: begin
          send_idle_pct = 65;
          stall_pct    <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct    <= 65;
        end
        default: begin
          send_idle_pct = 19;
          stall_pct    <= 19;
        end
      endcase
      phase_start = pairs_sent;
      while (pairs_sent - phase_start < PHASE_PAIRS)
        send_random_vector(24);
      in_valid <= 1'b0;
      while (pending != 0) @(negedge clk);
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("** modal_assurance_criterion_top: PASSED **");
    else
      $display("** modal_assurance_criterion_top: FAILED **");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/mac_pkg.sv
rtl/mac_mul.sv
rtl/modal_assurance_criterion_top.sv
tb/mac_result_checker.sv
tb/modal_assurance_criterion_top_tb.sv
